>>> hdl/hsbp_pkg.sv
// Shared types and constants for the Huffman symbol bit packer.
package hsbp_pkg;

    localparam int SYMBOL_COUNT_DEF  = 256;
    localparam int MAX_CODE_BITS_DEF = 8;

    localparam int SYM_W   = 8;
    localparam int CODE_W  = 8;
    localparam int LEN_W   = 4;
    localparam int ACC_N_W = 3;
    localparam int BYTE_W  = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_ENCODE  = 2'd0,
        OP_UNKNOWN = 2'd1,
        OP_FLUSH   = 2'd2
    } t_op;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef struct packed {
        t_op    op;
        t_entry entry;
    } t_qent;

endpackage

>>> hdl/hsbp_front.sv
// Front end: accepts beats, holds the code table and classifies each beat.
module hsbp_front #(
    parameter int SYMBOL_COUNT  = hsbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_BITS = hsbp_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_kind,
    input  logic [hsbp_pkg::SYM_W-1:0] i_symbol,
    input  logic [hsbp_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hsbp_pkg::LEN_W-1:0] i_code_length,
    input  logic [hsbp_pkg::QCNT_W-1:0] i_q_count,
    output logic                       o_push,
    output hsbp_pkg::t_qent            o_push_ent
);

    localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    hsbp_pkg::t_entry r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_tab_vld;

    hsbp_pkg::t_entry r_rd_entry;
    logic             r_rd_vld;
    logic             r_s1_valid;
    logic             r_s1_flush;
    logic             r_s1_oob;

    logic                          accept;
    logic                          oob;
    logic [AW-1:0]                 addr;
    logic [hsbp_pkg::LEN_W-1:0]    len_sat;
    logic [hsbp_pkg::CODE_W-1:0]   mask;
    hsbp_pkg::t_entry              wr_entry;
    logic                          is_load;
    logic                          is_work;

    assign o_stall = (i_q_count + hsbp_pkg::QCNT_W'(r_s1_valid))
                     >= hsbp_pkg::QCNT_W'(hsbp_pkg::QUEUE_DEPTH);
    assign accept  = i_valid && !o_stall;
    assign oob     = {1'b0, i_symbol} >= (hsbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
    assign addr    = i_symbol[AW-1:0];
    assign is_load = (i_kind == hsbp_pkg::KIND_LOAD);
    assign is_work = (i_kind == hsbp_pkg::KIND_ENCODE) || (i_kind == hsbp_pkg::KIND_FLUSH);

    always_comb begin
        if (i_code_length > hsbp_pkg::LEN_W'(MAX_CODE_BITS)) begin
            len_sat = hsbp_pkg::LEN_W'(MAX_CODE_BITS);
        end else begin
            len_sat = i_code_length;
        end
        mask           = hsbp_pkg::CODE_W'(16'hFF00 >> len_sat);
        wr_entry.code  = i_code_bits & mask;
        wr_entry.len   = len_sat;
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_load && !oob) begin
            r_mem[addr] <= wr_entry;
        end
        r_rd_entry <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld  <= '0;
            r_rd_vld   <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_flush <= 1'b0;
            r_s1_oob   <= 1'b0;
        end else begin
            if (accept && is_load && !oob) begin
                r_tab_vld[addr] <= 1'b1;
            end
            r_rd_vld   <= r_tab_vld[addr];
            r_s1_valid <= accept && is_work;
            r_s1_flush <= (i_kind == hsbp_pkg::KIND_FLUSH);
            r_s1_oob   <= oob;
        end
    end

    always_comb begin
        o_push           = r_s1_valid;
        o_push_ent.entry = r_rd_entry;
        if (r_s1_flush) begin
            o_push_ent.op = hsbp_pkg::OP_FLUSH;
        end else if (r_s1_oob || !r_rd_vld || (r_rd_entry.len == '0)) begin
            o_push_ent.op = hsbp_pkg::OP_UNKNOWN;
        end else begin
            o_push_ent.op = hsbp_pkg::OP_ENCODE;
        end
    end

endmodule

>>> hdl/hsbp_queue.sv
// Short queue between the classifying front end and the packing back end.
module hsbp_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  hsbp_pkg::t_qent              i_push_ent,
    input  logic                         i_pop,
    output logic                         o_head_valid,
    output hsbp_pkg::t_qent              o_head,
    output logic [hsbp_pkg::QCNT_W-1:0]  o_count
);

    hsbp_pkg::t_qent r_mem [hsbp_pkg::QUEUE_DEPTH];
    logic [hsbp_pkg::QPTR_W-1:0] r_wp;
    logic [hsbp_pkg::QPTR_W-1:0] r_rp;
    logic [hsbp_pkg::QCNT_W-1:0] r_count;

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rp];
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + hsbp_pkg::QCNT_W'(i_push) - hsbp_pkg::QCNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ((r_count != hsbp_pkg::QCNT_W'(hsbp_pkg::QUEUE_DEPTH)) || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

endmodule

>>> hdl/hsbp_back.sv
// Back end: merges code bits into the byte accumulator and holds the output beat.
module hsbp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  hsbp_pkg::t_qent               i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hsbp_pkg::BYTE_W-1:0]   o_packed_byte,
    output logic [hsbp_pkg::LEN_W-1:0]    o_valid_bits,
    output logic                          o_is_last,
    output logic                          o_unknown_symbol
);

    logic [hsbp_pkg::BYTE_W-1:0]  r_acc;
    logic [hsbp_pkg::ACC_N_W-1:0] r_cnt;
    logic                         r_out_valid;
    logic [hsbp_pkg::BYTE_W-1:0]  r_out_byte;
    logic [hsbp_pkg::LEN_W-1:0]   r_out_bits;
    logic                         r_out_last;
    logic                         r_out_unk;

    logic [hsbp_pkg::BYTE_W-1:0]  n_acc;
    logic [hsbp_pkg::ACC_N_W-1:0] n_cnt;
    logic                         n_emit;
    logic [hsbp_pkg::BYTE_W-1:0]  n_byte;
    logic [hsbp_pkg::LEN_W-1:0]   n_bits;
    logic                         n_last;
    logic                         n_unk;

    logic [2*hsbp_pkg::BYTE_W-1:0] wide;
    logic [hsbp_pkg::LEN_W-1:0]    total;

    assign o_pop = i_head_valid && (!r_out_valid || !i_stall);

    always_comb begin
        wide  = {r_acc, hsbp_pkg::BYTE_W'(0)}
              | ({i_head.entry.code, hsbp_pkg::BYTE_W'(0)} >> r_cnt);
        total = hsbp_pkg::LEN_W'(r_cnt) + i_head.entry.len;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_emit = 1'b0;
        n_byte = '0;
        n_bits = '0;
        n_last = 1'b0;
        n_unk  = 1'b0;
        unique case (i_head.op)
            hsbp_pkg::OP_ENCODE: begin
                if (total >= hsbp_pkg::LEN_W'(hsbp_pkg::BYTE_W)) begin
                    n_emit = 1'b1;
                    n_byte = wide[2*hsbp_pkg::BYTE_W-1:hsbp_pkg::BYTE_W];
                    n_bits = hsbp_pkg::LEN_W'(hsbp_pkg::BYTE_W);
                    n_acc  = wide[hsbp_pkg::BYTE_W-1:0];
                    n_cnt  = hsbp_pkg::ACC_N_W'(total - hsbp_pkg::LEN_W'(hsbp_pkg::BYTE_W));
                end else begin
                    n_acc = wide[2*hsbp_pkg::BYTE_W-1:hsbp_pkg::BYTE_W];
                    n_cnt = hsbp_pkg::ACC_N_W'(total);
                end
            end
            hsbp_pkg::OP_UNKNOWN: begin
                n_emit = 1'b1;
                n_unk  = 1'b1;
            end
            hsbp_pkg::OP_FLUSH: begin
                n_emit = 1'b1;
                n_byte = r_acc;
                n_bits = hsbp_pkg::LEN_W'(r_cnt);
                n_last = 1'b1;
                n_acc  = '0;
                n_cnt  = '0;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
            end
            if (o_pop && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) begin
            r_out_byte <= n_byte;
            r_out_bits <= n_bits;
            r_out_last <= n_last;
            r_out_unk  <= n_unk;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_packed_byte    = r_out_byte;
    assign o_valid_bits     = r_out_bits;
    assign o_is_last        = r_out_last;
    assign o_unknown_symbol = r_out_unk;

    a_unk_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_unk) |-> (!r_out_last && (r_out_bits == '0)
                                        && (r_out_byte == '0)))
        else $error("error beat carries data");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_head.op == hsbp_pkg::OP_FLUSH)) |=> ((r_acc == '0) && (r_cnt == '0)))
        else $error("accumulator not cleared after flush");

endmodule

>>> hdl/huffman_symbol_bit_packer.sv
// Top level of the Huffman symbol bit packer.
//
// The input channel (i_valid, o_stall) carries one beat per item: kind 0 loads
// a code table entry, kind 1 encodes a symbol, kind 2 flushes the partial last
// byte, and kind 3 is dropped. The output channel (o_valid, i_stall) carries
// one beat per full byte, per flushed byte, or per unknown symbol.
// A beat may be accepted every cycle while o_stall is low, so the block
// sustains one item per cycle unless the queue fills. An encode or flush
// passes through the registered table read stage and the queue head, from
// which it is merged into the output register, before it reaches the output.
// A four-entry queue separates the table lookup from the packer. When the
// receiver stalls, the output beat holds, the queue fills, and o_stall rises
// once the queue and the lookup stage together hold four items.
// Reset clears the table valid bits, so every entry reads as unused, and
// empties the accumulator and the queue; no clearing pass runs.
module huffman_symbol_bit_packer #(
    parameter int SYMBOL_COUNT  = hsbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_BITS = hsbp_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_kind,
    input  logic [hsbp_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hsbp_pkg::CODE_W-1:0] i_code_bits,
    input  logic [hsbp_pkg::LEN_W-1:0]  i_code_length,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hsbp_pkg::BYTE_W-1:0] o_packed_byte,
    output logic [hsbp_pkg::LEN_W-1:0]  o_valid_bits,
    output logic                        o_is_last,
    output logic                        o_unknown_symbol
);

    logic                        push;
    hsbp_pkg::t_qent             push_ent;
    logic                        pop;
    logic                        head_valid;
    hsbp_pkg::t_qent             head;
    logic [hsbp_pkg::QCNT_W-1:0] q_count;

    hsbp_front #(
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_push_ent    (push_ent)
    );

    hsbp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_ent   (push_ent),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_count      (q_count)
    );

    hsbp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_packed_byte    (o_packed_byte),
        .o_valid_bits     (o_valid_bits),
        .o_is_last        (o_is_last),
        .o_unknown_symbol (o_unknown_symbol)
    );

endmodule

>>> dv/huffman_symbol_bit_packer_tb.sv
// Self-checking testbench for the Huffman symbol bit packer with a built-in predictor.
module huffman_symbol_bit_packer_tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ITEMS_PHASE   = 267;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [hsbp_pkg::BYTE_W-1:0] packed_byte;
        logic [hsbp_pkg::LEN_W-1:0]  valid_bits;
        logic                        is_last;
        logic                        unknown_symbol;
    } t_packed_beat;

    typedef struct packed {
        hsbp_pkg::t_kind             kind;
        logic [hsbp_pkg::SYM_W-1:0]  sym;
        logic [hsbp_pkg::CODE_W-1:0] bits;
        logic [hsbp_pkg::LEN_W-1:0]  len;
        bit                          typed;
        t_packed_beat                want;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [1:0]                    i_kind = hsbp_pkg::KIND_NONE;
    logic [hsbp_pkg::SYM_W-1:0]    i_symbol = '0;
    logic [hsbp_pkg::CODE_W-1:0]   i_code_bits = '0;
    logic [hsbp_pkg::LEN_W-1:0]    i_code_length = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [hsbp_pkg::BYTE_W-1:0]   o_packed_byte;
    logic [hsbp_pkg::LEN_W-1:0]    o_valid_bits;
    logic                          o_is_last;
    logic                          o_unknown_symbol;

    hsbp_pkg::t_entry              code_tab [hsbp_pkg::SYMBOL_COUNT_DEF];
    logic [hsbp_pkg::BYTE_W-1:0]   pend_bits;
    logic [hsbp_pkg::ACC_N_W-1:0]  pend_n;
    t_packed_beat                  expected_bytes [$];
    t_row                          stim_rows [$];

    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  errors = 0;
    int                  cycles = 0;
    bit                  typed_now = 1'b0;
    t_packed_beat        typed_want = '0;

    huffman_symbol_bit_packer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_symbol         (i_symbol),
        .i_code_bits      (i_code_bits),
        .i_code_length    (i_code_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_packed_byte    (o_packed_byte),
        .o_valid_bits     (o_valid_bits),
        .o_is_last        (o_is_last),
        .o_unknown_symbol (o_unknown_symbol)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    function automatic void pack_item(input hsbp_pkg::t_kind kind,
                                      input logic [hsbp_pkg::SYM_W-1:0] sym,
                                      input logic [hsbp_pkg::CODE_W-1:0] bits,
                                      input logic [hsbp_pkg::LEN_W-1:0] len,
                                      output bit emits, output t_packed_beat res);
        logic [hsbp_pkg::LEN_W-1:0] len_sat;
        logic [15:0]                wide;
        int                         total;
        emits = 1'b0;
        res = '0;
        case (kind)
            hsbp_pkg::KIND_LOAD: begin
                len_sat = (len > hsbp_pkg::MAX_CODE_BITS_DEF)
                          ? hsbp_pkg::LEN_W'(hsbp_pkg::MAX_CODE_BITS_DEF) : len;
                code_tab[sym].code = bits & ~(8'hFF >> len_sat);
                code_tab[sym].len  = len_sat;
            end
            hsbp_pkg::KIND_ENCODE: begin
                emits = 1'b1;
                if (code_tab[sym].len == '0) begin
                    res.unknown_symbol = 1'b1;
                end else begin
                    wide = {pend_bits, 8'h00} | ({code_tab[sym].code, 8'h00} >> pend_n);
                    total = int'(pend_n) + int'(code_tab[sym].len);
                    if (total >= 8) begin
                        res.packed_byte = wide[15:8];
                        res.valid_bits  = hsbp_pkg::LEN_W'(8);
                        pend_bits = wide[7:0];
                        pend_n = hsbp_pkg::ACC_N_W'(total - 8);
                    end else begin
                        emits = 1'b0;
                        pend_bits = wide[15:8];
                        pend_n = hsbp_pkg::ACC_N_W'(total);
                    end
                end
            end
            hsbp_pkg::KIND_FLUSH: begin
                emits = 1'b1;
                res.packed_byte = pend_bits;
                res.valid_bits  = hsbp_pkg::LEN_W'(pend_n);
                res.is_last     = 1'b1;
                pend_bits = '0;
                pend_n = '0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input t_packed_beat want,
                                            input t_packed_beat got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s", cycles, what);
            $display("  expected byte=%02h bits=%0d last=%0b unk=%0b",
                     want.packed_byte, want.valid_bits, want.is_last,
                     want.unknown_symbol);
            $display("  got      byte=%02h bits=%0d last=%0b unk=%0b",
                     got.packed_byte, got.valid_bits, got.is_last,
                     got.unknown_symbol);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_packed_beat got;
        t_packed_beat want;
        t_packed_beat res;
        bit           emits;
        if (!i_rst_n) begin
            foreach (code_tab[s]) begin
                code_tab[s] = '0;
            end
            pend_bits = '0;
            pend_n = '0;
            expected_bytes.delete();
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_packed_byte, o_valid_bits, o_is_last, o_unknown_symbol};
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected beat", '0, got);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.packed_byte !== want.packed_byte
                        || got.valid_bits !== want.valid_bits
                        || got.is_last !== want.is_last
                        || got.unknown_symbol !== want.unknown_symbol) begin
                        report_mismatch("wrong beat", want, got);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                pack_item(hsbp_pkg::t_kind'(i_kind), i_symbol, i_code_bits, i_code_length,
                          emits, res);
                if (emits) begin
                    expected_bytes.push_back(typed_now ? typed_want : res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("huffman_symbol_bit_packer_tb NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic send_beat(input hsbp_pkg::t_kind kind,
                             input logic [hsbp_pkg::SYM_W-1:0] sym,
                             input logic [hsbp_pkg::CODE_W-1:0] bits,
                             input logic [hsbp_pkg::LEN_W-1:0] len,
                             input bit typed, input t_packed_beat want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_symbol      <= sym;
        i_code_bits   <= bits;
        i_code_length <= len;
        typed_now  = typed;
        typed_want = want;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic add_row(input hsbp_pkg::t_kind kind,
                           input logic [hsbp_pkg::SYM_W-1:0] sym,
                           input logic [hsbp_pkg::CODE_W-1:0] bits,
                           input logic [hsbp_pkg::LEN_W-1:0] len,
                           input bit typed, input t_packed_beat want);
        stim_rows.push_back({kind, sym, bits, len, typed, want});
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_bytes.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_random(input int items, input int idle_pct, input int stall_pct);
        int                          r;
        int                          done;
        hsbp_pkg::t_kind             kind;
        logic [hsbp_pkg::SYM_W-1:0]  sym;
        logic [hsbp_pkg::CODE_W-1:0] bits;
        logic [hsbp_pkg::LEN_W-1:0]  len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < items) begin
            r = $urandom_range(0, 99);
            bits = hsbp_pkg::CODE_W'($urandom_range(0, 255));
            sym = hsbp_pkg::SYM_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 82) begin
                sym = hsbp_pkg::SYM_W'($urandom_range(0, 15));
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                len = '0;
            end else if (r < 92) begin
                len = hsbp_pkg::LEN_W'($urandom_range(1, 8));
            end else begin
                len = hsbp_pkg::LEN_W'($urandom_range(9, 15));
            end
            r = $urandom_range(0, 99);
            if (r < 14) begin
                kind = hsbp_pkg::KIND_LOAD;
            end else if (r < 86) begin
                kind = hsbp_pkg::KIND_ENCODE;
            end else if (r < 95) begin
                kind = hsbp_pkg::KIND_FLUSH;
            end else begin
                kind = hsbp_pkg::KIND_NONE;
            end
            send_beat(kind, sym, bits, len, 1'b0, '0);
            if (kind != hsbp_pkg::KIND_NONE) begin
                done++;
            end
        end
    endtask

    initial begin
        add_row(hsbp_pkg::KIND_FLUSH,  8'h00, 8'h00, 4'd0,  1'b1, {8'h00, 4'd0, 1'b1, 1'b0});
        add_row(hsbp_pkg::KIND_ENCODE, 8'h00, 8'h00, 4'd0,  1'b1, {8'h00, 4'd0, 1'b0, 1'b1});
        add_row(hsbp_pkg::KIND_ENCODE, 8'hFF, 8'hFF, 4'd15, 1'b1, {8'h00, 4'd0, 1'b0, 1'b1});
        add_row(hsbp_pkg::KIND_NONE,   8'h5A, 8'hA5, 4'd8,  1'b0, '0);
        add_row(hsbp_pkg::KIND_LOAD,   8'h00, 8'hFF, 4'd8,  1'b0, '0);
        add_row(hsbp_pkg::KIND_LOAD,   8'hFF, 8'hA5, 4'd15, 1'b0, '0);
        add_row(hsbp_pkg::KIND_LOAD,   8'h01, 8'hFF, 4'd1,  1'b0, '0);
        add_row(hsbp_pkg::KIND_LOAD,   8'h02, 8'h00, 4'd3,  1'b0, '0);
        add_row(hsbp_pkg::KIND_LOAD,   8'h03, 8'hC0, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_ENCODE, 8'h00, 8'h00, 4'd0,  1'b1, {8'hFF, 4'd8, 1'b0, 1'b0});
        add_row(hsbp_pkg::KIND_ENCODE, 8'hFF, 8'h00, 4'd0,  1'b1, {8'hA5, 4'd8, 1'b0, 1'b0});
        add_row(hsbp_pkg::KIND_ENCODE, 8'h01, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_ENCODE, 8'h02, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_ENCODE, 8'h00, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_ENCODE, 8'h03, 8'h00, 4'd0,  1'b1, {8'h00, 4'd0, 1'b0, 1'b1});
        add_row(hsbp_pkg::KIND_FLUSH,  8'h00, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_FLUSH,  8'h00, 8'h00, 4'd0,  1'b1, {8'h00, 4'd0, 1'b1, 1'b0});
        add_row(hsbp_pkg::KIND_LOAD,   8'h04, 8'h61, 4'd7,  1'b0, '0);
        add_row(hsbp_pkg::KIND_ENCODE, 8'h04, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_ENCODE, 8'h04, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_ENCODE, 8'h01, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_ENCODE, 8'hFF, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_FLUSH,  8'h00, 8'h00, 4'd0,  1'b0, '0);
        add_row(hsbp_pkg::KIND_NONE,   8'hFF, 8'hFF, 4'd15, 1'b0, '0);

        repeat (RESET_CYCLES) begin
            @(negedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 7;
        recv_stall_pct = 49;
        foreach (stim_rows[n]) begin
            send_beat(stim_rows[n].kind, stim_rows[n].sym, stim_rows[n].bits,
                      stim_rows[n].len, stim_rows[n].typed, stim_rows[n].want);
        end
        typed_now = 1'b0;

        run_random(ITEMS_PHASE, 7, 49);
        wait_drained();
        run_random(ITEMS_PHASE, 49, 7);
        wait_drained();
        run_random(ITEMS_PHASE, 0, 0);
        wait_drained();
        repeat (DRAIN_CYCLES) begin
            @(negedge i_clk);
        end

        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("huffman_symbol_bit_packer_tb OK");
        end else begin
            $display("huffman_symbol_bit_packer_tb NOT OK");
        end
        $finish;
    end

endmodule
